>>> rtl/rgbsat_pkg.sv
// shared types and constants for the hsl saturation adjust block
package rgbsat_pkg;

    localparam logic [9:0] GAIN_RESET = 10'd218;

    // hue sector base, in units of one sixth of a turn
    localparam logic [2:0] BASE_RED   = 3'd0;
    localparam logic [2:0] BASE_GREEN = 3'd2;
    localparam logic [2:0] BASE_BLUE  = 3'd4;
    localparam logic [2:0] BASE_WRAP  = 3'd6;

    typedef enum logic [1:0] {
        RAMP_UP,
        RAMP_HI,
        RAMP_DOWN,
        RAMP_LO
    } ramp_mode_t;

    // sideband carried alongside the divider stages
    typedef struct packed {
        logic [8:0] sum;
        logic [2:0] base;
        logic       neg;
        logic       last;
    } div_side_t;

endpackage

>>> rtl/rgbsat_if.sv
// channel interfaces: pixel in, pixel out and gain write
interface rgbsat_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       last_in;
    modport source (output valid, red_in, green_in, blue_in, last_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, last_in, output ready);
endinterface

interface rgbsat_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_out;
    modport source (output valid, red_out, green_out, blue_out, last_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_out, output ready);
endinterface

interface rgbsat_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] saturation_gain;
    modport source (output valid, saturation_gain, input ready);
    modport sink   (input valid, saturation_gain, output ready);
endinterface

>>> rtl/rgbsat_div2_pipe.sv
// two restoring dividers side by side, one quotient bit per stage
module rgbsat_div2_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [7:0]             num_a,
    input  logic [7:0]             dv_a,
    input  logic [7:0]             num_b,
    input  logic [7:0]             dv_b,
    input  rgbsat_pkg::div_side_t  side_in,
    output logic                   out_vld,
    output logic [FRAC_BITS:0]     quo_a,
    output logic [FRAC_BITS:0]     quo_b,
    output rgbsat_pkg::div_side_t  side_out
);
    import rgbsat_pkg::*;

    localparam int NST = FRAC_BITS + 1;

    logic [7:0]         rem_a_reg [0:NST-1];
    logic [7:0]         rem_b_reg [0:NST-1];
    logic [FRAC_BITS:0] quo_a_reg [0:NST-1];
    logic [FRAC_BITS:0] quo_b_reg [0:NST-1];
    logic [7:0]         dv_a_reg  [0:NST-1];
    logic [7:0]         dv_b_reg  [0:NST-1];
    div_side_t          side_reg  [0:NST-1];
    logic [NST-1:0]     vld_reg;

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [8:0]         pa;
        logic [8:0]         pb;
        logic [7:0]         dva;
        logic [7:0]         dvb;
        logic [FRAC_BITS:0] qa_prev;
        logic [FRAC_BITS:0] qb_prev;
        div_side_t          side_prev;
        logic               vld_prev;
        logic               ge_a;
        logic               ge_b;
        logic [8:0]         ra;
        logic [8:0]         rb;

        if (k == 0) begin : g_first
            assign pa        = {1'b0, num_a};
            assign pb        = {1'b0, num_b};
            assign dva       = dv_a;
            assign dvb       = dv_b;
            assign qa_prev   = '0;
            assign qb_prev   = '0;
            assign side_prev = side_in;
            assign vld_prev  = in_vld;
        end
        else begin : g_next
            assign pa        = {rem_a_reg[k-1], 1'b0};
            assign pb        = {rem_b_reg[k-1], 1'b0};
            assign dva       = dv_a_reg[k-1];
            assign dvb       = dv_b_reg[k-1];
            assign qa_prev   = quo_a_reg[k-1];
            assign qb_prev   = quo_b_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        always_comb
        begin
            ge_a = (pa >= {1'b0, dva});
            ge_b = (pb >= {1'b0, dvb});
            ra   = ge_a ? (pa - {1'b0, dva}) : pa;
            rb   = ge_b ? (pb - {1'b0, dvb}) : pb;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[k] <= ra[7:0];
                rem_b_reg[k] <= rb[7:0];
                quo_a_reg[k] <= qa_prev
                    | ({{FRAC_BITS{1'b0}}, ge_a} << (FRAC_BITS - k));
                quo_b_reg[k] <= qb_prev
                    | ({{FRAC_BITS{1'b0}}, ge_b} << (FRAC_BITS - k));
                dv_a_reg[k]  <= dva;
                dv_b_reg[k]  <= dvb;
                side_reg[k]  <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign quo_a    = quo_a_reg[NST-1];
    assign quo_b    = quo_b_reg[NST-1];
    assign side_out = side_reg[NST-1];

endmodule

>>> rtl/rgb_saturation_scale_hsl_unit.sv
// top level: rgb to hsl, saturation gain and clamp, hsl back to rgb
//
//  channel   dir  payload                                  handshake
//  pix_in    in   red_in green_in blue_in last_in          valid / ready
//  pix_out   out  red_out green_out blue_out last_out      valid / ready
//  cfg       in   saturation_gain (10 bits)                valid / ready
//
//  one pixel beat accepted per cycle while pix_out is not stalled; a beat passes
//  the input stage, FRAC_BITS + 1 divider stages and six arithmetic stages
//  the divider chain, one quotient bit per stage, sets the depth
//  a stall on pix_out freezes every stage at once; pix_in.ready follows
//  reset clears all valid bits and loads the gain with 218 (about 0.85)
//  cfg is always ready; the gain is picked up where a beat meets the multiplier
module rgb_saturation_scale_hsl_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    rgbsat_pix_in_if.sink  pix_in,
    rgbsat_pix_out_if.source pix_out,
    rgbsat_cfg_if.sink     cfg
);
    import rgbsat_pkg::*;

    // channel units carry 8 integer bits, ratios one bit over unity
    localparam int LW = FRAC_BITS + 8;
    localparam int SW = FRAC_BITS + 1;
    localparam int HW = FRAC_BITS + 3;
    localparam int GW = SW + 10;
    localparam int PW = LW + SW;

    localparam logic [HW-1:0] H_ONE   = HW'(1) << FRAC_BITS;
    localparam logic [HW-1:0] H_TWO   = HW'(2) << FRAC_BITS;
    localparam logic [HW-1:0] H_THREE = HW'(3) << FRAC_BITS;
    localparam logic [HW-1:0] H_FOUR  = HW'(4) << FRAC_BITS;
    localparam logic [HW-1:0] H_SIX   = HW'(6) << FRAC_BITS;
    localparam logic [SW-1:0] S_ONE   = SW'(1) << FRAC_BITS;
    localparam logic [LW-1:0] L_MAX   = LW'(255) << FRAC_BITS;

    // whole pipeline moves together unless the output beat is held
    logic en;
    assign en           = !pix_out.valid || pix_out.ready;
    assign pix_in.ready = en;

    // gain register
    logic [9:0] gain_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            gain_reg <= cfg.saturation_gain;
        end
    end

    // stage a: max, min, divider operands, hue sector
    logic [7:0] mx;
    logic [7:0] mn;
    logic [8:0] sum;
    logic [7:0] dlt;
    logic [8:0] den;
    logic [7:0] num_h;
    logic [2:0] base;
    logic       neg;
    logic       a_vld_reg;
    logic [7:0] a_num_s_reg;
    logic [7:0] a_dv_reg;
    logic [7:0] a_dh_reg;
    logic [7:0] a_num_h_reg;
    div_side_t  a_side_reg;

    always_comb
    begin
        mx = pix_in.red_in;
        mn = pix_in.red_in;
        if (pix_in.green_in > mx) mx = pix_in.green_in;
        if (pix_in.blue_in > mx)  mx = pix_in.blue_in;
        if (pix_in.green_in < mn) mn = pix_in.green_in;
        if (pix_in.blue_in < mn)  mn = pix_in.blue_in;
        sum = {1'b0, mx} + {1'b0, mn};
        dlt = mx - mn;
        den = (sum > 9'd255) ? (9'd510 - sum) : sum;
        if (mx == pix_in.red_in)
        begin
            if (pix_in.green_in >= pix_in.blue_in)
            begin
                base  = BASE_RED;
                neg   = 1'b0;
                num_h = pix_in.green_in - pix_in.blue_in;
            end
            else
            begin
                base  = BASE_WRAP;
                neg   = 1'b1;
                num_h = pix_in.blue_in - pix_in.green_in;
            end
        end
        else if (mx == pix_in.green_in)
        begin
            base  = BASE_GREEN;
            neg   = (pix_in.blue_in < pix_in.red_in);
            num_h = neg ? (pix_in.red_in - pix_in.blue_in)
                        : (pix_in.blue_in - pix_in.red_in);
        end
        else
        begin
            base  = BASE_BLUE;
            neg   = (pix_in.red_in < pix_in.green_in);
            num_h = neg ? (pix_in.green_in - pix_in.red_in)
                        : (pix_in.red_in - pix_in.green_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= pix_in.valid;
        end
    end

    // grey pixel: divide zero by one so both quotients come out zero
    // saturation divides by the lightness spread, hue by max minus min
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_num_s_reg     <= dlt;
            a_num_h_reg     <= (dlt == 8'd0) ? 8'd0 : num_h;
            a_dv_reg        <= (dlt == 8'd0) ? 8'd1 : den[7:0];
            a_dh_reg        <= (dlt == 8'd0) ? 8'd1 : dlt;
            a_side_reg.sum  <= sum;
            a_side_reg.base <= base;
            a_side_reg.neg  <= neg;
            a_side_reg.last <= pix_in.last_in;
        end
    end

    // divider chain: saturation ratio and hue fraction
    logic            dq_vld;
    logic [SW-1:0]   dq_s;
    logic [SW-1:0]   dq_h;
    div_side_t       dq_side;

    rgbsat_div2_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (a_vld_reg),
        .num_a    (a_num_s_reg),
        .dv_a     (a_dv_reg),
        .num_b    (a_num_h_reg),
        .dv_b     (a_dh_reg),
        .side_in  (a_side_reg),
        .out_vld  (dq_vld),
        .quo_a    (dq_s),
        .quo_b    (dq_h),
        .side_out (dq_side)
    );

    // stage h: hue from sector base, saturation times gain
    logic [HW-1:0] h_base;
    logic          h_vld_reg;
    logic [HW-1:0] h_h6_reg;
    logic [GW-1:0] h_sg_reg;
    logic [8:0]    h_sum_reg;
    logic          h_last_reg;

    assign h_base = HW'(dq_side.base) << FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            h_vld_reg <= dq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_h6_reg   <= dq_side.neg ? (h_base - HW'(dq_h)) : (h_base + HW'(dq_h));
            h_sg_reg   <= GW'(dq_s) * GW'(gain_reg);
            h_sum_reg  <= dq_side.sum;
            h_last_reg <= dq_side.last;
        end
    end

    // stage i: clamp saturation, hue positions of red and blue
    logic [GW-9:0] sg_shr;
    logic [HW-1:0] tr_sum;
    logic          i_vld_reg;
    logic [SW-1:0] i_s_reg;
    logic [HW-1:0] i_t_reg [0:2];
    logic [8:0]    i_sum_reg;
    logic          i_last_reg;

    assign sg_shr = h_sg_reg[GW-1:8];
    assign tr_sum = h_h6_reg + H_TWO;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            i_vld_reg <= h_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_s_reg    <= (sg_shr > (GW-8)'(S_ONE)) ? S_ONE : sg_shr[SW-1:0];
            i_t_reg[0] <= (tr_sum >= H_SIX) ? (tr_sum - H_SIX) : tr_sum;
            i_t_reg[1] <= h_h6_reg;
            i_t_reg[2] <= (h_h6_reg < H_TWO) ? (h_h6_reg + H_FOUR)
                                             : (h_h6_reg - H_TWO);
            i_sum_reg  <= h_sum_reg;
            i_last_reg <= h_last_reg;
        end
    end

    // stage j: lightness spread product, ramp segment of each channel
    logic [LW-1:0] j_l;
    logic [LW-1:0] j_mul_a;
    ramp_mode_t    j_mode [0:2];
    logic [SW-1:0] j_frac [0:2];
    logic          j_vld_reg;
    logic [PW-1:0] j_prod_reg;
    ramp_mode_t    j_mode_reg [0:2];
    logic [SW-1:0] j_frac_reg [0:2];
    logic [8:0]    j_sum_reg;
    logic          j_last_reg;

    assign j_l     = LW'(i_sum_reg) << (FRAC_BITS - 1);
    assign j_mul_a = (i_sum_reg < 9'd255) ? j_l : (L_MAX - j_l);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (i_t_reg[c] < H_ONE)
            begin
                j_mode[c] = RAMP_UP;
                j_frac[c] = i_t_reg[c][SW-1:0];
            end
            else if (i_t_reg[c] < H_THREE)
            begin
                j_mode[c] = RAMP_HI;
                j_frac[c] = '0;
            end
            else if (i_t_reg[c] < H_FOUR)
            begin
                j_mode[c] = RAMP_DOWN;
                j_frac[c] = SW'(H_FOUR - i_t_reg[c]);
            end
            else
            begin
                j_mode[c] = RAMP_LO;
                j_frac[c] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            j_vld_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_prod_reg <= PW'(j_mul_a) * PW'(i_s_reg);
            for (int c = 0; c < 3; c++)
            begin
                j_mode_reg[c] <= j_mode[c];
                j_frac_reg[c] <= j_frac[c];
            end
            j_sum_reg  <= i_sum_reg;
            j_last_reg <= i_last_reg;
        end
    end

    // stage k: q and p
    logic [LW-1:0] k_l;
    logic [LW-1:0] k_q;
    logic          k_vld_reg;
    logic [LW-1:0] k_q_reg;
    logic [LW-1:0] k_p_reg;
    ramp_mode_t    k_mode_reg [0:2];
    logic [SW-1:0] k_frac_reg [0:2];
    logic          k_last_reg;

    assign k_l = LW'(j_sum_reg) << (FRAC_BITS - 1);
    assign k_q = k_l + LW'(j_prod_reg >> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            k_vld_reg <= j_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_q_reg    <= k_q;
            k_p_reg    <= (k_l << 1) - k_q;
            k_mode_reg <= j_mode_reg;
            k_frac_reg <= j_frac_reg;
            k_last_reg <= j_last_reg;
        end
    end

    // stage l: ramp products, one per channel
    logic [LW-1:0] l_diff;
    logic          l_vld_reg;
    logic [PW-1:0] l_prod_reg [0:2];
    logic [LW-1:0] l_q_reg;
    logic [LW-1:0] l_p_reg;
    ramp_mode_t    l_mode_reg [0:2];
    logic          l_last_reg;

    assign l_diff = k_q_reg - k_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            l_vld_reg <= k_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                l_prod_reg[c] <= PW'(l_diff) * PW'(k_frac_reg[c]);
            end
            l_q_reg    <= k_q_reg;
            l_p_reg    <= k_p_reg;
            l_mode_reg <= k_mode_reg;
            l_last_reg <= k_last_reg;
        end
    end

    // stage m: pick the ramp value and truncate to 8 bits
    logic [LW-1:0] m_val [0:2];
    logic          out_vld_reg;
    logic [7:0]    out_ch_reg [0:2];
    logic          out_last_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            case (l_mode_reg[c])
                RAMP_UP, RAMP_DOWN: m_val[c] = l_p_reg + LW'(l_prod_reg[c] >> FRAC_BITS);
                RAMP_HI:            m_val[c] = l_q_reg;
                RAMP_LO:            m_val[c] = l_p_reg;
                default:            m_val[c] = l_p_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= l_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_ch_reg[c] <= m_val[c][FRAC_BITS+7:FRAC_BITS];
            end
            out_last_reg <= l_last_reg;
        end
    end

    assign pix_out.valid     = out_vld_reg;
    assign pix_out.red_out   = out_ch_reg[0];
    assign pix_out.green_out = out_ch_reg[1];
    assign pix_out.blue_out  = out_ch_reg[2];
    assign pix_out.last_out  = out_last_reg;

    // checks
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        h_vld_reg |-> (h_h6_reg < H_SIX))
        else $error("hue position out of range");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        i_vld_reg |-> (i_s_reg <= S_ONE))
        else $error("saturation above one after clamp");

    a_p_le_q: assert property (@(posedge clk) disable iff (!rst_n)
        k_vld_reg |-> (k_p_reg <= k_q_reg))
        else $error("p above q");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(l_q_reg) && $stable(l_vld_reg)))
        else $error("pipeline moved during stall");

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the hsl saturation adjust unit
`timescale 1ns / 1ps
module tb_top;
    import rgbsat_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    logic clk;
    logic rst_n;

    rgbsat_pix_in_if  pix_in ();
    rgbsat_pix_out_if pix_out ();
    rgbsat_cfg_if     cfg ();

    rgb_saturation_scale_hsl_unit #(.FRAC_BITS(FRAC)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in.sink),
        .pix_out (pix_out.source),
        .cfg     (cfg.sink)
    );

    // pixels waiting to be driven, and adjusted pixels still owed by the block
    pixel_t pending_pixels[$];
    pixel_t owed_pixels[$];
    logic [9:0] gain_model;
    int  error_count;
    bit  calm_mode;      // no idling on either side
    bit  hold_sink;      // long stall on the output side
    int  hold_cycles;
    bit  hold_request;
    bit  in_taken;       // input beat accepted at the last rising edge

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // channel ramp, t6 is six times the hue position
    function automatic logic [63:0] ramp_channel(logic [63:0] p, logic [63:0] q,
                                                 logic [63:0] t6);
        logic [63:0] one;
        one = 64'd1 << FRAC;
        if (t6 < one)
            return p + (((q - p) * t6) >> FRAC);
        if (t6 < 3 * one)
            return q;
        if (t6 < 4 * one)
            return p + (((q - p) * (4 * one - t6)) >> FRAC);
        return p;
    endfunction

    function automatic pixel_t adjust_saturation(pixel_t px, logic [9:0] gain);
        logic [63:0] one, r, g, b, mx, mn, sum, d, l, s, h6, q, p, tr, tb, den;
        logic [63:0] ro, go, bo;
        pixel_t res;
        one = 64'd1 << FRAC;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        d = mx - mn;
        l = (sum << FRAC) / 2;
        s = 0;
        h6 = 0;
        if (d != 0)
        begin
            den = (sum > 255) ? (510 - sum) : sum;
            s = (d << FRAC) / den;
            // ties: red beats green, green beats blue
            if (mx == r)
                h6 = (g >= b) ? ((g - b) << FRAC) / d
                              : 6 * one - (((b - g) << FRAC) / d);
            else if (mx == g)
                h6 = (b >= r) ? 2 * one + (((b - r) << FRAC) / d)
                              : 2 * one - (((r - b) << FRAC) / d);
            else
                h6 = (r >= g) ? 4 * one + (((r - g) << FRAC) / d)
                              : 4 * one - (((g - r) << FRAC) / d);
        end
        s = (s * gain) >> 8;
        if (s > one)
            s = one;
        if (s == 0)
        begin
            ro = l;
            go = l;
            bo = l;
        end
        else
        begin
            if (sum < 255)
                q = l + ((l * s) >> FRAC);
            else
                q = l + ((s * (255 * one - l)) >> FRAC);
            p = 2 * l - q;
            tr = h6 + 2 * one;
            if (tr >= 6 * one)
                tr = tr - 6 * one;
            tb = (h6 < 2 * one) ? h6 + 4 * one : h6 - 2 * one;
            ro = ramp_channel(p, q, tr);
            go = ramp_channel(p, q, h6);
            bo = ramp_channel(p, q, tb);
        end
        res.red = ro[FRAC +: 8];
        res.green = go[FRAC +: 8];
        res.blue = bo[FRAC +: 8];
        res.last = px.last;
        return res;
    endfunction

    // driver: offers the next pending pixel at the falling edge
    // a beat on offer stays unchanged until it is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                void'(pending_pixels.pop_front());
            if (!pix_in.valid || in_taken)
            begin
                if (pending_pixels.size() > 0 && (calm_mode || $urandom_range(99) >= 26))
                begin
                    pix_in.valid <= 1'b1;
                    pix_in.red_in <= pending_pixels[0].red;
                    pix_in.green_in <= pending_pixels[0].green;
                    pix_in.blue_in <= pending_pixels[0].blue;
                    pix_in.last_in <= pending_pixels[0].last;
                end
                else
                    pix_in.valid <= 1'b0;
            end
        end
    end

    // receiver side, with the long stall counted here
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request && !hold_sink)
            begin
                hold_sink = 1'b1;
                hold_cycles = 0;
            end
            if (hold_sink)
            begin
                hold_cycles++;
                if (hold_cycles > 3 * LATENCY)
                begin
                    hold_sink = 1'b0;
                    hold_request = 1'b0;
                end
            end
            pix_out.ready <= !hold_sink && (calm_mode || $urandom_range(99) >= 26);
        end
    end

    // monitor: prediction at input acceptance, compare at output acceptance
    always @(posedge clk)
    begin
        pixel_t got, want;
        if (rst_n)
        begin
            in_taken = pix_in.valid && pix_in.ready;
            if (pix_in.valid && pix_in.ready)
                owed_pixels.push_back(adjust_saturation({pix_in.red_in, pix_in.green_in,
                    pix_in.blue_in, pix_in.last_in}, gain_model));
            if (pix_out.valid && pix_out.ready)
            begin
                got = {pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                       pix_out.last_out};
                if (owed_pixels.size() == 0)
                begin
                    $error("unexpected output beat %h", got);
                    error_count++;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    if (got.red !== want.red)
                    begin
                        $error("red_out expected %0d got %0d", want.red, got.red);
                        error_count++;
                    end
                    if (got.green !== want.green)
                    begin
                        $error("green_out expected %0d got %0d", want.green, got.green);
                        error_count++;
                    end
                    if (got.blue !== want.blue)
                    begin
                        $error("blue_out expected %0d got %0d", want.blue, got.blue);
                        error_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_out expected %0d got %0d", want.last, got.last);
                        error_count++;
                    end
                end
            end
        end
        else
            in_taken = 1'b0;
    end

    task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
        pixel_t px;
        px = {r, g, b, last};
        pending_pixels.push_back(px);
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            push_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(15) == 0);
    endtask

    // wait for every owed pixel and let the pipe settle before a gain write
    task automatic drain();
        while (pending_pixels.size() > 0 || owed_pixels.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_gain(logic [9:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.saturation_gain <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        gain_model = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic [9:0] gains[6];
        gains = '{10'd0, 10'd512, 10'd1, 10'd1023, 10'd256, 10'd700};
        error_count = 0;
        gain_model = GAIN_RESET;
        calm_mode = 1'b0;
        hold_sink = 1'b0;
        hold_request = 1'b0;
        hold_cycles = 0;
        in_taken = 1'b0;
        rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.red_in = '0;
        pix_in.green_in = '0;
        pix_in.blue_in = '0;
        pix_in.last_in = 1'b0;
        pix_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.saturation_gain = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, grey, ties, every hue sector, near-zero saturation
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        push_pixel(8'd200, 8'd50, 8'd100, 1'b0);
        push_pixel(8'd50, 8'd200, 8'd100, 1'b0);
        push_pixel(8'd100, 8'd50, 8'd200, 1'b0);
        push_pixel(8'd128, 8'd127, 8'd127, 1'b0);
        push_pixel(8'd1, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd254, 8'd254, 1'b0);
        push_pixel(8'd127, 8'd128, 8'd0, 1'b1);
        push_random(60);
        drain();

        // long output stall with a busy, calm input so the pipe backs up
        calm_mode = 1'b1;
        push_random(80);
        hold_request = 1'b1;
        drain();
        calm_mode = 1'b0;

        foreach (gains[i])
        begin
            write_gain(gains[i]);
            push_pixel(8'd255, 8'd0, 8'd128, 1'b0);
            push_pixel(8'd10, 8'd9, 8'd9, 1'b1);
            push_random(i == 4 ? 20 : 45);
            drain();
        end
        write_gain(GAIN_RESET);
        push_random(30);
        drain();

        if (error_count == 0)
            $display("rgb_saturation_scale_hsl_unit verification clean");
        else
            $display("rgb_saturation_scale_hsl_unit verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("rgb_saturation_scale_hsl_unit verification failed");
        $finish;
    end
endmodule
